>>> rtl/dqsb_pkg.sv
package dqsb_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_WIDTH   = 32;
   localparam int MODE_WIDTH    = 3;
   localparam int STATUS_WIDTH  = 2;

   localparam logic [MODE_WIDTH-1:0] MODE_PUSH_ONE = 3'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_POP_ONE  = 3'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_SHOW_ONE = 3'd2;
   localparam logic [MODE_WIDTH-1:0] MODE_PUSH_TWO = 3'd3;
   localparam logic [MODE_WIDTH-1:0] MODE_POP_TWO  = 3'd4;
   localparam logic [MODE_WIDTH-1:0] MODE_SHOW_TWO = 3'd5;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNDERFLOW = 2'd2;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_POP,
      OP_SHOW
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_SHOW
   } back_state_type;

   typedef struct packed {
      op_type                  op;
      logic                    second;
      logic [VALUE_WIDTH-1:0]  value;
   } cmd_type;

endpackage

>>> rtl/dqsb_front.sv
module dqsb_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [dqsb_pkg::MODE_WIDTH-1:0]      req_mode,
   input  logic signed [dqsb_pkg::VALUE_WIDTH-1:0] req_push_value,
   output logic                                 cmd_valid,
   output dqsb_pkg::cmd_type                    cmd,
   input  logic                                 cmd_ready
);
   import dqsb_pkg::*;

   cmd_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   cmd_type     decoded;
   logic        known;
   logic        enq;
   logic        deq;

   always_comb begin
      decoded.value  = req_push_value;
      decoded.op     = OP_PUSH;
      decoded.second = 1'b0;
      known          = 1'b1;
      unique case (req_mode)
         MODE_PUSH_ONE: begin decoded.op = OP_PUSH; decoded.second = 1'b0; end
         MODE_POP_ONE:  begin decoded.op = OP_POP;  decoded.second = 1'b0; end
         MODE_SHOW_ONE: begin decoded.op = OP_SHOW; decoded.second = 1'b0; end
         MODE_PUSH_TWO: begin decoded.op = OP_PUSH; decoded.second = 1'b1; end
         MODE_POP_TWO:  begin decoded.op = OP_POP;  decoded.second = 1'b1; end
         MODE_SHOW_TWO: begin decoded.op = OP_SHOW; decoded.second = 1'b1; end
         default:       known = 1'b0;
      endcase
   end

   assign busy      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];

   // unused modes are taken and dropped
   assign enq = start && !busy && known;
   assign deq = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = enq ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = deq ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      priority if (enq && !deq) begin
         count_in = count_ff + 2'd1;
      end else if (deq && !enq) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         slot_ff[wr_ptr_ff] <= decoded;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("front queue count out of range");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("front queue pointers disagree with count");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 && !enq) |=> !cmd_valid)
      else $error("command appeared without a request");

endmodule

>>> rtl/dqsb_back.sv
module dqsb_back #(
   parameter int DEPTH = dqsb_pkg::DEPTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    cmd_valid,
   input  dqsb_pkg::cmd_type                       cmd,
   output logic                                    cmd_ready,
   output logic                                    rsp_strobe,
   output logic [dqsb_pkg::STATUS_WIDTH-1:0]       rsp_status,
   output logic signed [dqsb_pkg::VALUE_WIDTH-1:0] rsp_out_value,
   output logic                                    rsp_last
);
   import dqsb_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] TOP_MARK = PW'(DEPTH);
   localparam logic [PW-1:0] ONE      = PW'(1);

   logic [VALUE_WIDTH-1:0] mem [DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;
   logic [AW-1:0]          rd_addr;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;

   back_state_type state_ff, state_in;
   // queue one pointers are kept plus one so that the empty mark is zero
   logic [PW-1:0] h1p_ff, h1p_in, t1p_ff, t1p_in;
   logic [PW-1:0] h2_ff, h2_in, t2_ff, t2_in;
   logic          sel_ff, sel_in;
   logic [AW-1:0] cur_ff, cur_in;

   logic                    strobe_ff, strobe_in;
   logic [STATUS_WIDTH-1:0] status_ff, status_in;
   logic [VALUE_WIDTH-1:0]  value_ff, value_in;
   logic                    last_ff, last_in;

   logic [PW-1:0] h1m, t1m, t2m;
   logic [AW-1:0] h1a, t1a, h2a, t2a;
   logic          empty_one, empty_two;
   logic          empty_sel;
   logic          at_tail;

   assign h1m = h1p_ff - ONE;
   assign t1m = t1p_ff - ONE;
   assign t2m = t2_ff - ONE;
   assign h1a = h1m[AW-1:0];
   assign t1a = t1m[AW-1:0];
   assign h2a = h2_ff[AW-1:0];
   assign t2a = t2_ff[AW-1:0];
   assign empty_one = (h1p_ff == '0);
   assign empty_two = (h2_ff == TOP_MARK);
   assign empty_sel = cmd.second ? empty_two : empty_one;
   assign at_tail   = sel_ff ? (cur_ff == t2a) : (cur_ff == t1a);

   always_comb begin
      state_in  = state_ff;
      h1p_in    = h1p_ff;
      t1p_in    = t1p_ff;
      h2_in     = h2_ff;
      t2_in     = t2_ff;
      sel_in    = sel_ff;
      cur_in    = cur_ff;
      strobe_in = 1'b0;
      status_in = STATUS_OK;
      value_in  = '0;
      last_in   = 1'b1;
      cmd_ready = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = t1p_ff[AW-1:0];
      rd_addr   = cur_ff;

      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               sel_in = cmd.second;
               unique case (cmd.op)
                  OP_PUSH: begin
                     strobe_in = 1'b1;
                     // tails adjacent: no room left between the queues
                     if (t1p_ff >= t2_ff) begin
                        status_in = STATUS_OVERFLOW;
                     end else if (!cmd.second) begin
                        wr_en   = 1'b1;
                        wr_addr = t1p_ff[AW-1:0];
                        if (empty_one) h1p_in = ONE;
                        t1p_in = t1p_ff + ONE;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = t2m[AW-1:0];
                        if (empty_two) h2_in = TOP_MARK - ONE;
                        t2_in = t2m;
                     end
                  end
                  OP_POP: begin
                     if (empty_sel) begin
                        strobe_in = 1'b1;
                        status_in = STATUS_UNDERFLOW;
                     end else begin
                        rd_addr  = cmd.second ? h2a : h1a;
                        state_in = ST_POP;
                     end
                  end
                  OP_SHOW: begin
                     if (empty_sel) begin
                        strobe_in = 1'b1;
                        status_in = STATUS_UNDERFLOW;
                     end else begin
                        rd_addr  = cmd.second ? h2a : h1a;
                        cur_in   = rd_addr;
                        state_in = ST_SHOW;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_POP: begin
            strobe_in = 1'b1;
            value_in  = rd_data_ff;
            state_in  = ST_IDLE;
            if (!sel_ff) begin
               if (h1p_ff == t1p_ff) begin
                  h1p_in = '0;
                  t1p_in = '0;
               end else begin
                  h1p_in = h1p_ff + ONE;
               end
            end else begin
               if (h2_ff == t2_ff) begin
                  h2_in = TOP_MARK;
                  t2_in = TOP_MARK;
               end else begin
                  h2_in = h2_ff - ONE;
               end
            end
         end
         ST_SHOW: begin
            strobe_in = 1'b1;
            value_in  = rd_data_ff;
            last_in   = at_tail;
            if (at_tail) begin
               state_in = ST_IDLE;
            end else begin
               cur_in  = sel_ff ? (cur_ff - AW'(1)) : (cur_ff + AW'(1));
               rd_addr = cur_in;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         h1p_ff    <= '0;
         t1p_ff    <= '0;
         h2_ff     <= TOP_MARK;
         t2_ff     <= TOP_MARK;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         h1p_ff    <= h1p_in;
         t1p_ff    <= t1p_in;
         h2_ff     <= h2_in;
         t2_ff     <= t2_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff    <= sel_in;
      cur_ff    <= cur_in;
      status_ff <= status_in;
      value_ff  <= value_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= cmd.value;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_status    = status_ff;
   assign rsp_out_value = value_ff;
   assign rsp_last      = last_ff;

   a_tails_apart: assert property (@(posedge clock) disable iff (reset)
      t1p_ff <= t2_ff)
      else $error("queue tails crossed");

   a_one_order: assert property (@(posedge clock) disable iff (reset)
      (empty_one && t1p_ff == '0) || (!empty_one && h1p_ff <= t1p_ff))
      else $error("queue one pointers inconsistent");

   a_two_order: assert property (@(posedge clock) disable iff (reset)
      (empty_two && t2_ff == TOP_MARK) || (!empty_two && t2_ff <= h2_ff))
      else $error("queue two pointers inconsistent");

   a_pop_once: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |=> (state_ff == ST_IDLE && rsp_strobe && rsp_last))
      else $error("pop did not give a single final response");

endmodule

>>> rtl/dual_queue_shared_buffer_unit.sv
// Two FIFO queues in one buffer of DEPTH 32-bit entries: queue one grows up from
// entry 0, queue two down from the top. A request is taken when start is high and
// busy is low; busy rises only when the two-entry command queue between the
// decoder and the executing back end is full. Each response is on the rsp_ ports
// for one cycle, marked by rsp_strobe, and cannot be held off. The back end answers a
// push or a refused pop or show from its idle state, a pop from its pop state after a
// synchronous read of the buffer, and a show of n elements from its show state, one
// element per cycle; each response is registered. Modes 6 and 7 are taken and dropped.
module dual_queue_shared_buffer_unit #(
   parameter int DEPTH = dqsb_pkg::DEPTH_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [dqsb_pkg::MODE_WIDTH-1:0]         req_mode,
   input  logic signed [dqsb_pkg::VALUE_WIDTH-1:0] req_push_value,
   output logic                                    rsp_strobe,
   output logic [dqsb_pkg::STATUS_WIDTH-1:0]       rsp_status,
   output logic signed [dqsb_pkg::VALUE_WIDTH-1:0] rsp_out_value,
   output logic                                    rsp_last
);
   import dqsb_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_ready;

   dqsb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_mode       (req_mode),
      .req_push_value (req_push_value),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_ready      (cmd_ready)
   );

   dqsb_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_ready     (cmd_ready),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last)
   );

endmodule
